[hdl/wpst_pkg.sv]
// Shared types, constants and the arctangent table for the waypoint steering step.
// No dependencies; every other file in hdl/ imports this package.
package wpst_pkg;

    // Angle accumulator: 1/32768 degree, signed
    localparam int ANGLE_W = 25;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 25'sd2949120;
    localparam logic signed [ANGLE_W-1:0] BEARING_MAX  = 25'sd23040;
    localparam logic signed [ANGLE_W-1:0] BEARING_MIN  = -25'sd23040;

    // Result word: 74 bits of fields, padded to whole bytes
    localparam int OUT_DATA_W  = 80;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ARRIVE_RADIUS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_TOL     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_SPEED  = 2'd2;

    // Pre-rotation applied when the waypoint lies behind the vehicle
    typedef enum logic [1:0] {
        QUAD_NONE = 2'd0,
        QUAD_POS  = 2'd1,
        QUAD_NEG  = 2'd2
    } t_quad;

    typedef struct packed {
        logic [15:0] arrive_radius;
        logic [14:0] angle_tolerance;
        logic [6:0]  cruise_speed;
    } t_cfg;

    // atan(2^-i) in 1/32768 degree, rounded to nearest
    function automatic logic [20:0] atan_entry(input logic [4:0] idx);
        logic [20:0] v;
        begin
            case (idx)
                5'd0:    v = 21'd1474560;
                5'd1:    v = 21'd870484;
                5'd2:    v = 21'd459940;
                5'd3:    v = 21'd233473;
                5'd4:    v = 21'd117189;
                5'd5:    v = 21'd58652;
                5'd6:    v = 21'd29333;
                5'd7:    v = 21'd14667;
                5'd8:    v = 21'd7334;
                5'd9:    v = 21'd3667;
                5'd10:   v = 21'd1833;
                5'd11:   v = 21'd917;
                5'd12:   v = 21'd458;
                5'd13:   v = 21'd229;
                5'd14:   v = 21'd115;
                5'd15:   v = 21'd57;
                5'd16:   v = 21'd29;
                5'd17:   v = 21'd14;
                5'd18:   v = 21'd7;
                5'd19:   v = 21'd4;
                5'd20:   v = 21'd2;
                5'd21:   v = 21'd1;
                default: v = 21'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[hdl/wpst_front.sv]
// Front end: takes input words, sign-extends the offsets and classifies them
// (magnitudes, zero offset, quadrant pre-rotation) into a job. Uses wpst_pkg.
module wpst_front import wpst_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int IN_DATA_W   = 48,
    parameter int JOB_W       = 85
) (
    input  logic                 i_in_valid,
    input  logic [IN_DATA_W-1:0] i_in_data,
    output logic                 o_in_ready,
    output logic                 o_job_valid,
    output logic [JOB_W-1:0]     o_job,
    input  logic                 i_job_ready
);

    localparam int C = COORD_WIDTH;

    logic signed [C:0]  w_sx;
    logic signed [C:0]  w_sy;
    logic signed [C:0]  w_x0;
    logic signed [C:0]  w_y0;
    logic signed [C:0]  w_abs_x;
    logic signed [C:0]  w_abs_y;
    logic [15:0]        w_yaw;
    logic               w_zero;
    t_quad              w_quad;

    // Unpack and sign-extend
    assign w_sx  = (C+1)'($signed(i_in_data[C-1:0]));
    assign w_sy  = (C+1)'($signed(i_in_data[2*C-1:C]));
    assign w_yaw = i_in_data[2*C+15:2*C];

    assign w_abs_x = w_sx[C] ? -w_sx : w_sx;
    assign w_abs_y = w_sy[C] ? -w_sy : w_sy;
    assign w_zero  = (w_sx == '0) && (w_sy == '0);

    // Rotate by a quarter turn when the waypoint is behind
    always_comb begin
        if (!w_sx[C]) begin
            w_x0   = w_sx;
            w_y0   = w_sy;
            w_quad = QUAD_NONE;
        end else if (!w_sy[C]) begin
            w_x0   = w_sy;
            w_y0   = -w_sx;
            w_quad = QUAD_POS;
        end else begin
            w_x0   = -w_sy;
            w_y0   = w_sx;
            w_quad = QUAD_NEG;
        end
    end

    // Job layout from bit 0: |x|, |y|, x0, y0, quadrant, zero, yaw
    assign o_job = {w_yaw, w_zero, w_quad, w_y0, w_x0,
                    w_abs_y[C-1:0], w_abs_x[C-1:0]};
    assign o_job_valid = i_in_valid;
    assign o_in_ready  = i_job_ready;

endmodule

[hdl/wpst_queue.sv]
// Two-entry job queue between the front end and the back end.
// Holds job words of any width; imports wpst_pkg but takes nothing from it.
module wpst_queue import wpst_pkg::*; #(
    parameter int WIDTH = 85
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue fill count out of range");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue fill count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

[hdl/wpst_back.sv]
// Back end: squares and sums the offsets, runs the vectoring CORDIC and the
// bit-pair square root side by side, then decides and registers the result. Uses wpst_pkg.
module wpst_back import wpst_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int INDEX_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int JOB_W        = 85
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_job_valid,
    input  logic [JOB_W-1:0]      i_job,
    output logic                  o_job_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    input  logic                  i_out_ready
);

    localparam int C      = COORD_WIDTH;
    localparam int NW     = 2 * C;
    localparam int CW     = C + 10;
    localparam int ITER_N = (C > CORDIC_STEPS) ? C : CORDIC_STEPS;
    localparam int CNT_W  = ($clog2(ITER_N + 1) > 5) ? $clog2(ITER_N + 1) : 5;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQ_X   = 6'b000010,
        S_SQ_Y   = 6'b000100,
        S_ITER   = 6'b001000,
        S_ROUND  = 6'b010000,
        S_DECIDE = 6'b100000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [C-1:0]             r_ax;
    logic [C-1:0]             r_ay;
    logic signed [CW-1:0]     r_cx;
    logic signed [CW-1:0]     r_cy;
    logic signed [ANGLE_W-1:0] r_cz;
    logic                     r_zero;
    logic signed [15:0]       r_yaw;
    logic [NW-1:0]            r_sq_n;
    logic [NW:0]              r_sq_r;
    logic [NW:0]              r_sq_b;
    logic [15:0]              r_dist;
    logic signed [15:0]       r_bear;
    logic [INDEX_WIDTH-1:0]   r_wp_cnt;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out;

    // Job fields
    logic [C-1:0]             w_j_ax;
    logic [C-1:0]             w_j_ay;
    logic [C:0]               w_j_x0;
    logic [C:0]               w_j_y0;
    t_quad                    w_j_quad;
    logic                     w_j_zero;
    logic [15:0]              w_j_yaw;
    logic signed [ANGLE_W-1:0] w_j_z0;

    logic [C-1:0]             w_mul_op;
    logic [NW-1:0]            w_sq;
    logic signed [CW-1:0]     w_dx;
    logic signed [CW-1:0]     w_dy;
    logic signed [ANGLE_W-1:0] w_atan;
    logic                     w_cord_on;
    logic                     w_sqrt_on;
    logic [NW+1:0]            w_trial;
    logic                     w_fit;
    logic                     w_up;
    logic [C:0]               w_root;
    logic [32:0]              w_root_ext;
    logic [15:0]              w_dist;
    logic signed [ANGLE_W-1:0] w_zr;
    logic signed [15:0]       w_bear;
    logic                     w_pop;
    logic                     w_issue;
    logic                     w_reached;
    logic [15:0]              w_bear_mag;
    logic                     w_in_tol;
    logic [6:0]               w_speed;
    logic signed [16:0]       w_target;
    logic [INDEX_WIDTH-1:0]   w_wp_next;
    logic [31:0]              w_wp_ext;

    // Unpack job
    assign w_j_ax   = i_job[C-1:0];
    assign w_j_ay   = i_job[2*C-1:C];
    assign w_j_x0   = i_job[3*C:2*C];
    assign w_j_y0   = i_job[4*C+1:3*C+1];
    assign w_j_quad = t_quad'(i_job[4*C+3:4*C+2]);
    assign w_j_zero = i_job[4*C+4];
    assign w_j_yaw  = i_job[4*C+20:4*C+5];

    always_comb begin
        unique case (w_j_quad)
            QUAD_POS: w_j_z0 = QUARTER_TURN;
            QUAD_NEG: w_j_z0 = -QUARTER_TURN;
            default:  w_j_z0 = '0;
        endcase
    end

    assign w_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_job_ready = (r_state == S_IDLE);

    // Shared squaring multiplier
    assign w_mul_op = (r_state == S_SQ_X) ? r_ax : r_ay;
    assign w_sq     = NW'(w_mul_op) * NW'(w_mul_op);

    // CORDIC micro-rotation
    assign w_dx      = r_cy >>> r_cnt;
    assign w_dy      = r_cx >>> r_cnt;
    assign w_atan    = $signed({4'd0, atan_entry(r_cnt[4:0])});
    assign w_cord_on = (r_cnt < CNT_W'(CORDIC_STEPS));

    // Square root bit pair
    assign w_sqrt_on = (r_cnt < CNT_W'(C));
    assign w_trial   = {1'b0, r_sq_r} + {1'b0, r_sq_b};
    assign w_fit     = {2'b00, r_sq_n} >= w_trial;

    // Round root to nearest, saturate to 16 bits
    assign w_up       = {1'b0, r_sq_n} > r_sq_r;
    assign w_root     = r_sq_r[C:0] + (C+1)'(w_up);
    assign w_root_ext = 33'(w_root);
    assign w_dist     = (|w_root_ext[32:16]) ? 16'hFFFF : w_root_ext[15:0];

    // Bearing: accumulator / 256 rounded half up, then clamp
    assign w_zr = (r_cz + ANGLE_W'(128)) >>> 8;
    always_comb begin
        priority if (r_zero) begin
            w_bear = '0;
        end else if (w_zr > BEARING_MAX) begin
            w_bear = 16'(BEARING_MAX);
        end else if (w_zr < BEARING_MIN) begin
            w_bear = 16'(BEARING_MIN);
        end else begin
            w_bear = 16'(w_zr);
        end
    end

    // Decision
    assign w_issue    = (r_state == S_DECIDE) && (!r_out_valid || i_out_ready);
    assign w_reached  = (r_dist <= i_cfg.arrive_radius);
    assign w_bear_mag = r_bear[15] ? 16'(-r_bear) : r_bear;
    assign w_in_tol   = (w_bear_mag < {1'b0, i_cfg.angle_tolerance});
    assign w_speed    = (!w_reached && w_in_tol) ? i_cfg.cruise_speed : 7'd0;
    assign w_target   = w_reached ? 17'sd0 : (17'(r_yaw) + 17'(r_bear));
    assign w_wp_next  = (w_reached && (r_wp_cnt != '1)) ? (r_wp_cnt + 1'b1) : r_wp_cnt;
    assign w_wp_ext   = 32'(w_wp_next);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_job_valid) n_state = S_SQ_X;
            S_SQ_X:   n_state = S_SQ_Y;
            S_SQ_Y:   n_state = S_ITER;
            S_ITER:   if (r_cnt == CNT_W'(ITER_N - 1)) n_state = S_ROUND;
            S_ROUND:  n_state = S_DECIDE;
            S_DECIDE: if (w_issue) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wp_cnt    <= INDEX_WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SQ_Y) begin
                r_cnt <= '0;
            end else if (r_state == S_ITER) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_issue) begin
                r_wp_cnt    <= w_wp_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ax   <= w_j_ax;
            r_ay   <= w_j_ay;
            r_cx   <= CW'($signed({w_j_x0, 8'd0}));
            r_cy   <= CW'($signed({w_j_y0, 8'd0}));
            r_cz   <= w_j_z0;
            r_zero <= w_j_zero;
            r_yaw  <= w_j_yaw;
        end
        if (r_state == S_SQ_X) begin
            r_sq_n <= w_sq;
        end
        if (r_state == S_SQ_Y) begin
            r_sq_n <= r_sq_n + w_sq;
            r_sq_r <= '0;
            r_sq_b <= (NW+1)'(1) << (NW - 2);
        end
        if (r_state == S_ITER) begin
            if (w_cord_on) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_atan;
                end else begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_atan;
                end
            end
            if (w_sqrt_on) begin
                if (w_fit) begin
                    r_sq_n <= r_sq_n - NW'(w_trial);
                    r_sq_r <= (r_sq_r >> 1) + r_sq_b;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_b <= r_sq_b >> 2;
            end
        end
        if (r_state == S_ROUND) begin
            r_dist <= w_dist;
            r_bear <= w_bear;
        end
        if (w_issue) begin
            r_out <= {6'd0, w_wp_ext[15:0], r_dist, r_bear, w_target,
                      !w_reached, w_speed, w_reached};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_counter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp_cnt != '0)
        else $error("waypoint counter reached zero");
    a_counter_moves_on_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_wp_cnt)) |->
            $past(w_issue && w_reached))
        else $error("waypoint counter changed without an arrival");
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_sq_b == '0))
        else $error("square root not finished before rounding");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_cnt < CNT_W'(ITER_N)))
        else $error("iteration count overran");
`endif

endmodule

[hdl/waypoint_steering_step.sv]
// Waypoint steering step, top level: configuration registers, front end,
// job queue and back end. Depends on wpst_pkg, wpst_front, wpst_queue, wpst_back.
//
// Each input word carries a waypoint offset (rel_x, rel_y, signed Q8.8 m) and
// the current yaw; each yields exactly one result word with bearing, distance,
// speed command, target yaw and the waypoint number. The back end handles one
// item at a time; the CORDIC and the square root share one iteration loop.
// A two-entry queue lets the input side keep accepting while the back end
// works, and the result register lets the next item proceed while a result
// waits. Write configuration only while the block is idle.
module waypoint_steering_step import wpst_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int INDEX_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: rel_x, rel_y, current_yaw, zero pad
    input  logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata from bit 0: waypoint_reached, speed_percent, yaw_valid, target_yaw,
    // bearing, distance, waypoint_number, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IN_DATA_W = ((2*COORD_WIDTH + 16 + 7) / 8) * 8;
    localparam int JOB_W     = 4*COORD_WIDTH + 21;

    t_cfg             r_cfg;
    logic             w_fq_valid;
    logic [JOB_W-1:0] w_fq_job;
    logic             w_fq_ready;
    logic             w_qb_valid;
    logic [JOB_W-1:0] w_qb_job;
    logic             w_qb_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arrive_radius   <= 16'd38;
            r_cfg.angle_tolerance <= 15'd640;
            r_cfg.cruise_speed    <= 7'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ARRIVE_RADIUS: r_cfg.arrive_radius   <= i_cfg_wdata;
                CFG_ANGLE_TOL:     r_cfg.angle_tolerance <= i_cfg_wdata[14:0];
                CFG_CRUISE_SPEED:  r_cfg.cruise_speed    <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    wpst_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .IN_DATA_W   (IN_DATA_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .o_in_ready  (s_axis_tready),
        .o_job_valid (w_fq_valid),
        .o_job       (w_fq_job),
        .i_job_ready (w_fq_ready)
    );

    wpst_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .i_push_data  (w_fq_job),
        .o_push_ready (w_fq_ready),
        .o_pop_valid  (w_qb_valid),
        .o_pop_data   (w_qb_job),
        .i_pop_ready  (w_qb_ready)
    );

    wpst_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .INDEX_WIDTH  (INDEX_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .JOB_W        (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_qb_valid),
        .i_job       (w_qb_job),
        .o_job_ready (w_qb_ready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule
